// ===== hdl/sact_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants for the cache tag controller
// Holds policy codes, the register index, the LFSR seed and the controller/datapath struct.
// ----------------------------------------------------------------------------
package sact_pkg;

    typedef enum logic [1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_RAND = 2'd2,
        POL_LFU  = 2'd3
    } t_policy;

    localparam int unsigned REG_POLICY = 0;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;

    // controller -> datapath
    typedef struct packed {
        logic rd;      // read the addressed set
        logic upd;     // compute and write back the set
    } t_cmd;

endpackage

// ===== hdl/set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller: set-associative write-back tag controller
// Looks up each access, fills or evicts, and reports the way and write-back.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                 | payload
// request  | in        | i_in_valid / o_in_stall   | i_req_type, i_address
// result   | out       | o_out_valid / i_out_stall | o_hit .. o_victim_block_address
// config   | in        | APB psel/penable/pready   | replace_policy at 0x0
//
// Steps: each word is read from the set, then the set is updated and the result
//   registered; the result is held until taken, then the controller returns to idle.
// Reset: synchronous, clears the valid bits at once and seeds the LFSR; dirty,
//   counter and tag rows are only read through valid ways.
// Stalls: the result holds in its register while i_out_stall is high, and
//   no new request is taken until it leaves.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller
    import sact_pkg::*;
#(
    parameter int WAYS       = 4,
    parameter int SET_BITS   = 6,
    parameter int LINE_BITS  = 4,
    parameter int COUNT_BITS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [1:0]  o_way_used,
    output logic        o_fill_needed,
    output logic        o_writeback_needed,
    output logic [31:0] o_victim_block_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd       cmd;
    logic [1:0] r_policy;

    // register file: one policy register, other addresses ignored
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
        end else if (psel && penable && pwrite && pready
                     && paddr == 2'(REG_POLICY * 4)) begin
            r_policy <= pwdata[1:0];
        end
    end
    assign prdata = (paddr == 2'(REG_POLICY * 4)) ? {30'd0, r_policy} : 32'd0;

    sact_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    sact_dp #(
        .WAYS(WAYS), .SET_BITS(SET_BITS),
        .LINE_BITS(LINE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .i_policy               (r_policy),
        .i_req_type             (i_req_type),
        .i_address              (i_address),
        .o_hit                  (o_hit),
        .o_way_used             (o_way_used),
        .o_fill_needed          (o_fill_needed),
        .o_writeback_needed     (o_writeback_needed),
        .o_victim_block_address (o_victim_block_address)
    );
endmodule

// ===== hdl/sact_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ctrl: access sequencer
// Steps each word through set read, update and result hand-off.
// ----------------------------------------------------------------------------
module sact_ctrl
    import sact_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] { S_IDLE, S_LOOK, S_HOLD } t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.upd   = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_look_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> o_cmd.upd) else $error("update did not follow read");
    a_valid_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> o_out_valid) else $error("result not raised");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open while result held");
endmodule

// ===== hdl/sact_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_dp: tag, state and replacement datapath
// Set-wide memories, hit search, victim choice and counter update.
// ----------------------------------------------------------------------------
module sact_dp
    import sact_pkg::*;
#(
    parameter int WAYS       = 4,
    parameter int SET_BITS   = 6,
    parameter int LINE_BITS  = 4,
    parameter int COUNT_BITS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_policy,
    input  logic        i_req_type,
    input  logic [31:0] i_address,
    output logic        o_hit,
    output logic [1:0]  o_way_used,
    output logic        o_fill_needed,
    output logic        o_writeback_needed,
    output logic [31:0] o_victim_block_address
);
    localparam int TAG_W    = 32 - SET_BITS - LINE_BITS;
    localparam int NSETS    = 1 << SET_BITS;
    localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SB       = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int VB       = $clog2(WAYS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef logic [WAYS-1:0][TAG_W-1:0]      t_tags;
    typedef logic [WAYS-1:0][COUNT_BITS-1:0] t_cnts;

    // valid bits: flip-flops, cleared together at reset; dirty, counters and
    // tags are memory rows only looked at through valid ways
    logic [WAYS-1:0] r_valid   [NSETS];
    logic [WAYS-1:0] mem_dirty [NSETS];
    t_cnts           mem_cnt   [NSETS];
    t_tags           mem_tag   [NSETS];

    logic [SB-1:0]    r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_wr;
    t_tags            r_tags;
    logic [WAYS-1:0]  r_vld;
    logic [WAYS-1:0]  r_drt;
    t_cnts            r_cnts;
    logic [15:0]      r_lfsr;

    logic [SB-1:0] a_set;
    assign a_set = (SET_BITS > 0) ? SB'(i_address >> LINE_BITS) : '0;

    // read the whole set into registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_set  <= a_set;
            r_tag  <= TAG_W'(i_address >> (SET_BITS + LINE_BITS));
            r_wr   <= i_req_type;
            r_tags <= mem_tag[a_set];
            r_vld  <= r_valid[a_set];
            r_drt  <= mem_dirty[a_set];
            r_cnts <= mem_cnt[a_set];
        end
    end

    logic [WAYS-1:0]  vld, drt, n_drt;
    t_cnts            cnt, n_cnt;
    logic             hit, found, wb;
    logic [WB-1:0]    way;
    logic [VB-1:0]    nvalid;
    logic [15:0]      n_lfsr;
    logic [COUNT_BITS-1:0] least;
    logic             zfound;
    logic             cfill_lru;

    always_comb begin
        vld    = r_vld;
        drt    = r_drt;
        cnt    = r_cnts;
        n_cnt  = cnt;
        n_drt  = drt;
        hit    = 1'b0;
        found  = 1'b0;
        way    = '0;
        nvalid = '0;
        wb     = 1'b0;
        n_lfsr = r_lfsr;
        least  = cnt[0];
        zfound = 1'b0;
        cfill_lru = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (vld[i] && r_tags[i] == r_tag) begin
                hit = 1'b1;
                way = WB'(i);
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            if (vld[i]) nvalid = nvalid + VB'(1);
        end
        if (!hit) begin
            for (int i = WAYS - 1; i >= 0; i--) begin
                if (!vld[i]) begin
                    found = 1'b1;
                    way   = WB'(i);
                end
            end
            if (found) begin
                n_cnt[way] = '0;
                if (i_policy == POL_FIFO) n_cnt[way] = COUNT_BITS'(nvalid);
                else cfill_lru = 1'b1;
            end else begin
                case (t_policy'(i_policy))
                    POL_LRU, POL_FIFO: begin
                        for (int i = WAYS - 1; i >= 0; i--) begin
                            if (cnt[i] == '0) begin
                                way = WB'(i);
                                zfound = 1'b1;
                            end
                        end
                        if (!zfound) way = '0;
                    end
                    POL_RAND: begin
                        n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5],
                                  r_lfsr[15:1]};
                        way = WB'(n_lfsr % WAYS);
                    end
                    default: begin
                        for (int i = 1; i < WAYS; i++) begin
                            if (cnt[i] < least) begin
                                least = cnt[i];
                                way   = WB'(i);
                            end
                        end
                    end
                endcase
                wb = drt[way];
                if (i_policy == POL_FIFO) begin
                    for (int i = 0; i < WAYS; i++)
                        if (cnt[i] != '0) n_cnt[i] = cnt[i] - 1'b1;
                    n_cnt[way] = COUNT_BITS'(WAYS - 1);
                end else begin
                    if (i_policy == POL_LFU) n_cnt[way] = '0;
                    cfill_lru = 1'b1;
                end
            end
        end
        // touch: hit, or fill under any policy but FIFO
        if (hit || cfill_lru) begin
            case (t_policy'(i_policy))
                POL_LRU: begin
                    if (n_cnt[way] != CMAX) begin
                        for (int i = 0; i < WAYS; i++)
                            if (WB'(i) != way && vld[i] && n_cnt[i] != '0)
                                n_cnt[i] = n_cnt[i] - 1'b1;
                        n_cnt[way] = CMAX;
                    end
                end
                POL_RAND: n_cnt[way] = '0;
                POL_LFU:  if (n_cnt[way] != CMAX) n_cnt[way] = n_cnt[way] + 1'b1;
                default: ;
            endcase
        end
        // a fill starts clean; a write marks the line dirty
        if (!hit) n_drt[way] = r_wr;
        else if (r_wr) n_drt[way] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSETS; s++) begin
                r_valid[s] <= '0;
            end
            r_lfsr <= LFSR_SEED;
        end else if (i_cmd.upd) begin
            r_lfsr <= n_lfsr;
            if (!hit) r_valid[r_set][way] <= 1'b1;
        end
    end

    // write back the updated set row
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            mem_cnt[r_set]   <= n_cnt;
            mem_dirty[r_set] <= n_drt;
            if (!hit) mem_tag[r_set][way] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            o_hit              <= hit;
            o_way_used         <= 2'(way);
            o_fill_needed      <= !hit;
            o_writeback_needed <= wb;
            o_victim_block_address <= wb ?
                ((32'(r_tags[way]) << (SET_BITS + LINE_BITS))
                 | (32'(r_set) << LINE_BITS)) & ~((32'd1 << LINE_BITS) - 32'd1)
                : 32'd0;
        end
    end

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'd0) else $error("lfsr locked up");
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd && hit |-> !wb) else $error("write-back on a hit");
    a_wb_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd && wb |-> !found) else $error("write-back with free way");
endmodule
